// ===== design/rcoc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcoc_pkg
// shared constants, types and controller states of the rectangle coverage
// overlap counter
// ----------------------------------------------------------------------------
`default_nettype none

package rcoc_pkg;

	localparam int GRID_SIZE = 1024;
	localparam int CELL_W    = $clog2(GRID_SIZE);
	localparam int ADDR_W    = 2 * CELL_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	// wide enough for left + width and for the clipped end at the largest grid
	localparam int SUM_W     = 13;

	localparam int COORD_W   = 10;
	localparam int LEN_W     = 11;
	localparam int TOTAL_W   = 21;

	localparam logic [1:0]         COVER_SAT = 2'd2;
	localparam logic [1:0]         COVER_ONE = 2'd1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [SUM_W-1:0]   GRID_LIM  = SUM_W'(GRID_SIZE);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic issue;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic empty;
		logic last;
		logic out_full;
	} status_t;

endpackage

`default_nettype wire

// ===== design/rcoc_rect_if.sv =====
// ----------------------------------------------------------------------------
// rcoc_rect_if
// valid/ready channel carrying one rectangle per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface rcoc_rect_if;
	logic                          valid;
	logic                          ready;
	logic [rcoc_pkg::COORD_W-1:0]  left_x;
	logic [rcoc_pkg::COORD_W-1:0]  top_y;
	logic [rcoc_pkg::LEN_W-1:0]    rect_width;
	logic [rcoc_pkg::LEN_W-1:0]    rect_height;

	modport source (output valid, left_x, top_y, rect_width, rect_height, input ready);
	modport sink   (input valid, left_x, top_y, rect_width, rect_height, output ready);
endinterface

`default_nettype wire

// ===== design/rcoc_count_if.sv =====
// ----------------------------------------------------------------------------
// rcoc_count_if
// valid/ready channel carrying the overlap total per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface rcoc_count_if;
	logic                          valid;
	logic                          ready;
	logic [rcoc_pkg::TOTAL_W-1:0]  overlap_cells;

	modport source (output valid, overlap_cells, input ready);
	modport sink   (input valid, overlap_cells, output ready);
endinterface

`default_nettype wire

// ===== design/rcoc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcoc_ctrl
// sequencer: clearing pass, rectangle load, cell scan, drain and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module rcoc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              out_ready,
	input  wire rcoc_pkg::status_t status,
	output rcoc_pkg::cmd_t         cmd
);

	rcoc_pkg::state_t state_q;
	rcoc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcoc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rcoc_pkg::ST_CLEAR: begin
				if (status.clear_last) state_d = rcoc_pkg::ST_IDLE;
			end
			rcoc_pkg::ST_IDLE: begin
				if (in_valid) state_d = rcoc_pkg::ST_SCAN;
			end
			rcoc_pkg::ST_SCAN: begin
				if (status.empty || status.last) state_d = rcoc_pkg::ST_DRAIN;
			end
			rcoc_pkg::ST_DRAIN: begin
				state_d = rcoc_pkg::ST_DONE;
			end
			rcoc_pkg::ST_DONE: begin
				if (!status.out_full || out_ready) state_d = rcoc_pkg::ST_IDLE;
			end
			default: state_d = rcoc_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			rcoc_pkg::ST_CLEAR: cmd.clear = 1'b1;
			rcoc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			rcoc_pkg::ST_SCAN:  cmd.issue = !status.empty;
			rcoc_pkg::ST_DRAIN: cmd = '0;
			rcoc_pkg::ST_DONE:  cmd.publish = !status.out_full || out_ready;
			default:            cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/rcoc_dp.sv =====
// ----------------------------------------------------------------------------
// rcoc_dp
// coverage memory, cell address counters, read-modify-write stage, running
// total and output register
// ----------------------------------------------------------------------------
`default_nettype none

module rcoc_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rcoc_pkg::cmd_t                cmd,
	output rcoc_pkg::status_t                  status,
	input  wire logic [rcoc_pkg::COORD_W-1:0]  left_x,
	input  wire logic [rcoc_pkg::COORD_W-1:0]  top_y,
	input  wire logic [rcoc_pkg::LEN_W-1:0]    rect_width,
	input  wire logic [rcoc_pkg::LEN_W-1:0]    rect_height,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic [rcoc_pkg::TOTAL_W-1:0]       overlap_cells
);

	localparam int SW = rcoc_pkg::SUM_W;
	localparam int CW = rcoc_pkg::CELL_W;
	localparam int AW = rcoc_pkg::ADDR_W;
	localparam int TW = rcoc_pkg::TOTAL_W;

	logic [1:0]    cov_mem_q [rcoc_pkg::MEM_DEPTH];

	logic [AW-1:0] clr_q;
	logic [SW-1:0] x0_q, y0_q, xe_q, ye_q;
	logic [CW-1:0] x_q, y_q;
	logic          valid_s1;
	logic [AW-1:0] addr_s1;
	logic [1:0]    rd_data_s1;
	logic [TW-1:0] total_q;
	logic          out_valid_q;
	logic [TW-1:0] out_data_q;

	logic [SW-1:0] x_sum, y_sum, x_end, y_end;
	logic [SW-1:0] x_nxt, y_nxt;
	logic          y_wrap;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [1:0]    wr_data;
	logic          hit_two;

	// clipped end coordinates of the incoming rectangle
	assign x_sum = SW'(left_x) + SW'(rect_width);
	assign y_sum = SW'(top_y) + SW'(rect_height);
	assign x_end = (x_sum > rcoc_pkg::GRID_LIM) ? rcoc_pkg::GRID_LIM : x_sum;
	assign y_end = (y_sum > rcoc_pkg::GRID_LIM) ? rcoc_pkg::GRID_LIM : y_sum;

	assign x_nxt  = SW'(x_q) + SW'(1);
	assign y_nxt  = SW'(y_q) + SW'(1);
	assign y_wrap = (y_nxt == ye_q);

	assign status.clear_last = &clr_q;
	assign status.empty      = (x0_q >= xe_q) || (y0_q >= ye_q);
	assign status.last       = y_wrap && (x_nxt == xe_q);
	assign status.out_full   = out_valid_q;

	// clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// rectangle bounds and scan position
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q <= SW'(left_x);
			y0_q <= SW'(top_y);
			xe_q <= x_end;
			ye_q <= y_end;
			x_q  <= CW'(left_x);
			y_q  <= CW'(top_y);
		end else if (cmd.issue) begin
			if (y_wrap) begin
				y_q <= y0_q[CW-1:0];
				x_q <= x_q + CW'(1);
			end else begin
				y_q <= y_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) addr_s1 <= {x_q, y_q};
	end

	// cells of one rectangle are distinct, so the write-back never races a read
	assign hit_two = (rd_data_s1 == rcoc_pkg::COVER_ONE);
	assign wr_en   = cmd.clear || (valid_s1 && (rd_data_s1 < rcoc_pkg::COVER_SAT));
	assign wr_addr = cmd.clear ? clr_q : addr_s1;
	assign wr_data = cmd.clear ? 2'd0 : rd_data_s1 + 2'd1;

	always_ff @(posedge clk) begin
		if (wr_en) cov_mem_q[wr_addr] <= wr_data;
		if (cmd.issue) rd_data_s1 <= cov_mem_q[{x_q, y_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (valid_s1 && hit_two && (total_q != rcoc_pkg::TOTAL_MAX)) begin
			total_q <= total_q + TW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) out_data_q <= total_q;
	end

	assign out_valid     = out_valid_q;
	assign overlap_cells = out_data_q;

	a_total_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (total_q >= $past(total_q)))
		else $error("overlap total decreased");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (total_q == $past(total_q)) || (total_q == $past(total_q) + TW'(1)))
		else $error("overlap total moved by more than one");

	a_no_scan_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !valid_s1 && !cmd.issue && !cmd.publish)
		else $error("cell scan overlaps the clearing pass");

	a_publish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid_q && (out_data_q == $past(total_q)))
		else $error("published result does not match total");

endmodule

`default_nettype wire

// ===== design/rectangle_coverage_overlap_count.sv =====
// ----------------------------------------------------------------------------
// rectangle_coverage_overlap_count
// paints rectangles into a saturating coverage grid and reports how many
// cells are covered two or more times
// ----------------------------------------------------------------------------
// rect (sink): one rectangle per transaction (left_x, top_y, rect_width,
// rect_height); cells beyond the grid edge are skipped.
// count (source): one transaction per rectangle with overlap_cells, the
// running number of cells covered by two or more rectangles.
// after reset a clearing pass writes every cell of the 2^20-entry coverage
// memory, one per cycle; rect.ready stays low meanwhile and
// the total starts at zero.
// the result register fills after one read-modify-write of the memory per
// covered cell (clipped width * clipped height cells), through its single
// read and single write port, plus drain and hand-off; an empty rectangle
// issues no read. a new rectangle is accepted only back in idle, after the
// previous one has been handed off to the output register.
// the result sits in an output register; the next rectangle is accepted and
// scanned while it waits, and the block only holds in its last step when the
// register is still occupied because count.ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_coverage_overlap_count (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rcoc_rect_if.sink    rect,
	rcoc_count_if.source count
);

	rcoc_pkg::cmd_t    cmd;
	rcoc_pkg::status_t status;

	rcoc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rect.valid),
		.in_ready  (rect.ready),
		.out_ready (count.ready),
		.status    (status),
		.cmd       (cmd)
	);

	rcoc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.left_x        (rect.left_x),
		.top_y         (rect.top_y),
		.rect_width    (rect.rect_width),
		.rect_height   (rect.rect_height),
		.out_ready     (count.ready),
		.out_valid     (count.valid),
		.overlap_cells (count.overlap_cells)
	);

endmodule

`default_nettype wire

// ===== sim/rectangle_coverage_overlap_count_checker.sv =====
// ----------------------------------------------------------------------------
// rectangle_coverage_overlap_count_checker
// watches the rect and count channels, keeps its own saturating coverage grid
// and running overlap total, and compares every count transaction with the
// total predicted for the oldest outstanding rectangle
// ----------------------------------------------------------------------------

module rectangle_coverage_overlap_count_checker (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rcoc_rect_if       rect,
	rcoc_count_if      count,
	output int unsigned fail_count,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 10;

	bit [1:0]                        coverage [rcoc_pkg::MEM_DEPTH];
	bit                              grid_dirty = 1'b1;
	logic [rcoc_pkg::TOTAL_W-1:0]    overlap_sum;
	logic [rcoc_pkg::TOTAL_W-1:0]    expected_totals [$];
	int unsigned                     result_idx;

	// paints one rectangle, clipped at the grid edge, and returns the new total
	function automatic logic [rcoc_pkg::TOTAL_W-1:0] paint_rect(
		input logic [rcoc_pkg::COORD_W-1:0] x0,
		input logic [rcoc_pkg::COORD_W-1:0] y0,
		input logic [rcoc_pkg::LEN_W-1:0]   w,
		input logic [rcoc_pkg::LEN_W-1:0]   h
	);
		int          x_end;
		int          y_end;
		int unsigned idx;
		x_end = int'(x0) + int'(w);
		y_end = int'(y0) + int'(h);
		if (x_end > rcoc_pkg::GRID_SIZE)
			x_end = rcoc_pkg::GRID_SIZE;
		if (y_end > rcoc_pkg::GRID_SIZE)
			y_end = rcoc_pkg::GRID_SIZE;
		for (int x = int'(x0); x < x_end; x++) begin
			for (int y = int'(y0); y < y_end; y++) begin
				idx = x * rcoc_pkg::GRID_SIZE + y;
				if (coverage[idx] < rcoc_pkg::COVER_SAT) begin
					coverage[idx] = coverage[idx] + 2'd1;
					if (coverage[idx] == rcoc_pkg::COVER_SAT &&
					    overlap_sum != rcoc_pkg::TOTAL_MAX)
						overlap_sum = overlap_sum + 1'b1;
				end
			end
		end
		return overlap_sum;
	endfunction

	task automatic log_failure(input string msg);
		if (fail_count < MAX_REPORTS)
			$display("[%0t] ERROR: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			if (grid_dirty) begin
				foreach (coverage[i])
					coverage[i] = 2'd0;
				grid_dirty = 1'b0;
			end
			overlap_sum = '0;
			expected_totals.delete();
			result_idx = 0;
			fail_count = 0;
		end else begin
			if (count.valid && count.ready) begin
				if (expected_totals.size() == 0) begin
					log_failure($sformatf("count transaction %0d with no rectangle outstanding, got %0d",
						result_idx, count.overlap_cells));
				end else if (count.overlap_cells !== expected_totals[0]) begin
					log_failure($sformatf("count transaction %0d: overlap_cells expected %0d, got %0d",
						result_idx, expected_totals[0], count.overlap_cells));
					void'(expected_totals.pop_front());
				end else begin
					void'(expected_totals.pop_front());
				end
				result_idx++;
			end
			if (rect.valid && rect.ready) begin
				grid_dirty = 1'b1;
				expected_totals.insert(expected_totals.size(), paint_rect(rect.left_x,
					rect.top_y, rect.rect_width, rect.rect_height));
			end
		end
		pending = expected_totals.size();
	end

endmodule

// ===== sim/rectangle_coverage_overlap_count_tb.sv =====
// ----------------------------------------------------------------------------
// rectangle_coverage_overlap_count_tb
// drives rectangles into the overlap counter with random sender gaps and
// receiver stalls: a directed set of corner, clipping, empty and saturation
// cases, then random rectangles mostly packed into a small area so cells
// overlap often; the checker predicts and compares every result
// ----------------------------------------------------------------------------

module rectangle_coverage_overlap_count_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// the limit covers the clearing pass after reset, which runs without a transaction
	localparam int unsigned STALL_LIMIT      = 3_200_000;
	localparam int          RANDOM_PER_PHASE = 160;
	localparam int          TAIL_CYCLES      = 64;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned quiet_cycles;

	rcoc_rect_if  rect_ch ();
	rcoc_count_if count_ch ();

	rectangle_coverage_overlap_count dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rect   (rect_ch),
		.count  (count_ch)
	);

	rectangle_coverage_overlap_count_checker overlap_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.rect       (rect_ch),
		.count      (count_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		count_ch.ready = arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// ends the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (rect_ch.valid && rect_ch.ready) || (count_ch.valid && count_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_rect(
		input logic [rcoc_pkg::COORD_W-1:0] x,
		input logic [rcoc_pkg::COORD_W-1:0] y,
		input logic [rcoc_pkg::LEN_W-1:0]   w,
		input logic [rcoc_pkg::LEN_W-1:0]   h
	);
		while ($urandom_range(99) < send_idle_pct) begin
			rect_ch.valid       = 1'b0;
			rect_ch.left_x      = rcoc_pkg::COORD_W'($urandom);
			rect_ch.top_y       = rcoc_pkg::COORD_W'($urandom);
			rect_ch.rect_width  = rcoc_pkg::LEN_W'($urandom);
			rect_ch.rect_height = rcoc_pkg::LEN_W'($urandom);
			@(negedge clk);
		end
		rect_ch.valid       = 1'b1;
		rect_ch.left_x      = x;
		rect_ch.top_y       = y;
		rect_ch.rect_width  = w;
		rect_ch.rect_height = h;
		do
			@(posedge clk);
		while (!rect_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		rect_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic pick_random_rect(
		output logic [rcoc_pkg::COORD_W-1:0] x,
		output logic [rcoc_pkg::COORD_W-1:0] y,
		output logic [rcoc_pkg::LEN_W-1:0]   w,
		output logic [rcoc_pkg::LEN_W-1:0]   h
	);
		int unsigned kind;
		kind = $urandom_range(99);
		x = rcoc_pkg::COORD_W'($urandom);
		y = rcoc_pkg::COORD_W'($urandom);
		w = rcoc_pkg::LEN_W'($urandom);
		h = rcoc_pkg::LEN_W'($urandom);
		if (kind < 70) begin
			// dense corner, overlaps and saturation happen here
			x = rcoc_pkg::COORD_W'($urandom_range(47));
			y = rcoc_pkg::COORD_W'($urandom_range(47));
			w = rcoc_pkg::LEN_W'($urandom_range(12, 1));
			h = rcoc_pkg::LEN_W'($urandom_range(12, 1));
		end else if (kind < 80) begin
			// raw size runs far past the edge, clipped part stays narrow
			if ($urandom_range(1)) begin
				x = rcoc_pkg::COORD_W'($urandom_range(1023, 1008));
				h = rcoc_pkg::LEN_W'($urandom_range(24));
			end else begin
				y = rcoc_pkg::COORD_W'($urandom_range(1023, 1008));
				w = rcoc_pkg::LEN_W'($urandom_range(24));
			end
		end else if (kind < 88) begin
			if ($urandom_range(1))
				w = '0;
			else
				h = '0;
		end else if (kind < 96) begin
			w = rcoc_pkg::LEN_W'($urandom_range(8, 1));
			h = rcoc_pkg::LEN_W'($urandom_range(8, 1));
		end else begin
			x = rcoc_pkg::COORD_W'($urandom_range(63));
			y = rcoc_pkg::COORD_W'($urandom_range(63));
			w = rcoc_pkg::LEN_W'($urandom_range(64, 16));
			h = rcoc_pkg::LEN_W'($urandom_range(64, 16));
		end
	endtask

	initial begin
		logic [rcoc_pkg::COORD_W-1:0] x;
		logic [rcoc_pkg::COORD_W-1:0] y;
		logic [rcoc_pkg::LEN_W-1:0]   w;
		logic [rcoc_pkg::LEN_W-1:0]   h;
		rect_ch.valid       = 1'b0;
		rect_ch.left_x      = '0;
		rect_ch.top_y       = '0;
		rect_ch.rect_width  = '0;
		rect_ch.rect_height = '0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		arst_n              = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single cell painted three times: 0 -> 1 -> 2 -> stays saturated
		send_rect(10'd0, 10'd0, 11'd1, 11'd1);
		send_rect(10'd0, 10'd0, 11'd1, 11'd1);
		send_rect(10'd0, 10'd0, 11'd1, 11'd1);
		// empty rectangles
		send_rect(10'd0, 10'd0, 11'd0, 11'd5);
		send_rect(10'd0, 10'd0, 11'd5, 11'd0);
		send_rect(10'd0, 10'd0, 11'd0, 11'd0);
		send_rect(10'd1023, 10'd1023, 11'd0, 11'd1024);
		send_rect(10'd1023, 10'd1023, 11'd2047, 11'd0);
		// far corner, second one clipped to the same cell
		send_rect(10'd1023, 10'd1023, 11'd1, 11'd1);
		send_rect(10'd1023, 10'd1023, 11'd1024, 11'd1024);
		// clipped edge strips
		send_rect(10'd1023, 10'd0, 11'd1024, 11'd4);
		send_rect(10'd0, 10'd1023, 11'd3, 11'd1024);
		send_rect(10'd1020, 10'd1020, 11'd2047, 11'd2047);
		// full-width row twice, full-height column across it
		send_rect(10'd0, 10'd5, 11'd1024, 11'd1);
		send_rect(10'd5, 10'd0, 11'd1, 11'd1024);
		send_rect(10'd0, 10'd5, 11'd1024, 11'd1);
		// partial overlap of two squares
		send_rect(10'd100, 10'd100, 11'd8, 11'd8);
		send_rect(10'd104, 10'd104, 11'd8, 11'd8);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 60;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 60;
				end
				default: begin
					send_idle_pct  = 7;
					recv_stall_pct = 7;
				end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				pick_random_rect(x, y, w, h);
				send_rect(x, y, w, h);
			end
			wait_drained();
		end

		recv_stall_pct = 0;
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
